FILE: sv/pcmr_pkg.sv
// Shared types, codes and constants of the PCM linear gain ramp core.
// No dependencies; every other file of the core imports this package.
package pcmr_pkg;

   localparam int DATA_W    = 32;
   localparam int GAIN_W    = 8;
   localparam int FMT_W     = 3;
   localparam int CH_REG_W  = 4;
   localparam int CSR_IDX_W = 2;
   localparam int QUEUE_DEPTH = 2;

   localparam int DEF_MAX_CHANNELS = 8;
   localparam int DEF_GAIN_STEPS   = 256;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_TOTAL    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CHANNELS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FORMAT   = 2'd2;

   // reset values of the registers
   localparam logic [DATA_W-1:0]   TOTAL_RESET    = '0;
   localparam logic [CH_REG_W-1:0] CHANNELS_RESET = 4'd2;

   // command codes
   localparam logic FUNC_SAMPLE  = 1'b0;
   localparam logic FUNC_RESTART = 1'b1;

   // sample formats
   localparam logic [FMT_W-1:0] FMT_S8    = 3'd0;
   localparam logic [FMT_W-1:0] FMT_U8    = 3'd1;
   localparam logic [FMT_W-1:0] FMT_S16LE = 3'd2;
   localparam logic [FMT_W-1:0] FMT_S16BE = 3'd3;
   localparam logic [FMT_W-1:0] FMT_S24LE = 3'd4;
   localparam logic [FMT_W-1:0] FMT_S24BE = 3'd5;
   localparam logic [FMT_W-1:0] FMT_S32LE = 3'd6;
   localparam logic [FMT_W-1:0] FMT_S32BE = 3'd7;
   localparam logic [FMT_W-1:0] FORMAT_RESET = FMT_S16LE;

   // U8 offset binary bias
   localparam logic [7:0] U8_BIAS = 8'h80;

   // one classified sample word on its way to the gain datapath
   typedef struct packed {
      logic [DATA_W-1:0] word;
      logic [GAIN_W-1:0] gain;
      logic              done;
   } q_entry_type;

endpackage

FILE: sv/pcmr_div.sv
// Serial restoring divider, one quotient bit per cycle, for ramp resync.
// Depends on pcmr_pkg.
module pcmr_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [pcmr_pkg::DATA_W-1:0] dividend,
   input  logic [pcmr_pkg::DATA_W-1:0] divisor,
   output logic                        done,
   output logic [pcmr_pkg::DATA_W-1:0] quotient,
   output logic [pcmr_pkg::DATA_W-1:0] remainder
);
   import pcmr_pkg::*;

   localparam int CNT_W = $clog2(DATA_W + 1);

   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] dsr_ff, dsr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DATA_W:0]   trial;

   always_comb begin
      trial   = {rem_ff, quo_ff[DATA_W-1]} - {1'b0, dsr_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CNT_W'(DATA_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DATA_W]) begin
            rem_in = trial[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DATA_W-2:0], quo_ff[DATA_W-1]};
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

FILE: sv/pcmr_front.sv
// Front end: accepts words, keeps the frame/gain counters, classifies items.
// Depends on pcmr_pkg and pcmr_div (resync of the gain counters).
module pcmr_front #(
   parameter int MAX_CHANNELS = pcmr_pkg::DEF_MAX_CHANNELS,
   parameter int GAIN_STEPS   = pcmr_pkg::DEF_GAIN_STEPS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_func,
   input  logic [pcmr_pkg::DATA_W-1:0]   req_sample_word,
   input  logic                          req_ramp_down,
   input  logic [pcmr_pkg::DATA_W-1:0]   total_frames,
   input  logic [pcmr_pkg::CH_REG_W-1:0] channel_count,
   input  logic                          total_written,
   input  logic                          queue_full,
   output logic                          push,
   output pcmr_pkg::q_entry_type         entry,
   output logic                          busy
);
   import pcmr_pkg::*;

   localparam int GI_W  = $clog2(GAIN_STEPS + 1);
   localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CNT_W = ($clog2(MAX_CHANNELS + 1) > CH_REG_W) ?
                          $clog2(MAX_CHANNELS + 1) : CH_REG_W;
   localparam logic [GI_W-1:0]   GI_SAT  = GI_W'(GAIN_STEPS);
   localparam logic [GI_W-1:0]   GI_TOP  = GI_W'(GAIN_STEPS - 1);
   localparam logic [GAIN_W-1:0] GAIN_TOP = GAIN_W'(GAIN_STEPS - 1);
   localparam logic [CNT_W-1:0]  CH_MAX  = CNT_W'(MAX_CHANNELS);

   // step = total_frames / GAIN_STEPS by reciprocal multiplication, exact for 32-bit lengths
   localparam int                STEP_SH  = DATA_W + $clog2(GAIN_STEPS);
   localparam int                PROD_W   = 2 * DATA_W + 1;
   localparam logic [DATA_W:0]   STEP_REC = (DATA_W + 1)'(((64'd1 << STEP_SH) +
                                            64'(GAIN_STEPS) - 64'd1) / 64'(GAIN_STEPS));

   // resync sequencer codes
   localparam logic [2:0] RS_IDLE      = 3'd0;
   localparam logic [2:0] RS_STEP      = 3'd1;
   localparam logic [2:0] RS_GAIN      = 3'd2;
   localparam logic [2:0] RS_GAIN_WAIT = 3'd3;

   logic [DATA_W-1:0] frame_ff, frame_in;
   logic [DATA_W-1:0] phase_ff, phase_in;
   logic [DATA_W-1:0] step_ff, step_in;
   logic [GI_W-1:0]   gi_ff, gi_in;
   logic [CH_W-1:0]   ch_ff, ch_in;
   logic [2:0]        rs_ff, rs_in;

   logic              accept, past_end, gi_over;
   logic [CNT_W-1:0]  nch, ch_next;
   logic [GAIN_W-1:0] gain;

   logic [PROD_W-1:0] step_prod;
   logic [DATA_W-1:0] step_quo;

   logic              div_start, div_done;
   logic [DATA_W-1:0] div_dividend, div_divisor, div_quo, div_rem;

   pcmr_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign busy      = (rs_ff != RS_IDLE);
   assign req_stall = busy || queue_full;
   assign accept    = req_valid && !req_stall;
   assign push      = accept && (req_func == FUNC_SAMPLE);
   assign past_end  = (frame_ff >= total_frames);
   assign gi_over   = (gi_ff > GI_TOP);

   always_comb begin
      if (req_ramp_down) begin
         gain = gi_over ? '0 : GAIN_TOP - GAIN_W'(gi_ff);
      end else begin
         gain = gi_over ? GAIN_TOP : GAIN_W'(gi_ff);
      end
   end

   assign entry.word = req_sample_word;
   assign entry.gain = gain;
   assign entry.done = past_end;

   // clamp channel count to 1..MAX_CHANNELS
   always_comb begin
      if (channel_count == '0) begin
         nch = CNT_W'(1);
      end else if (CNT_W'(channel_count) > CH_MAX) begin
         nch = CH_MAX;
      end else begin
         nch = CNT_W'(channel_count);
      end
      ch_next = CNT_W'(ch_ff) + CNT_W'(1);
   end

   assign step_prod    = PROD_W'(total_frames) * PROD_W'(STEP_REC);
   assign step_quo     = DATA_W'(step_prod >> STEP_SH);

   assign div_start    = (rs_ff == RS_GAIN);
   assign div_dividend = frame_ff;
   assign div_divisor  = step_ff;

   always_comb begin
      frame_in = frame_ff;
      phase_in = phase_ff;
      step_in  = step_ff;
      gi_in    = gi_ff;
      ch_in    = ch_ff;
      rs_in    = rs_ff;

      if (accept) begin
         if (req_func == FUNC_RESTART) begin
            frame_in = '0;
            phase_in = '0;
            gi_in    = '0;
            ch_in    = '0;
         end else if (!past_end) begin
            if (ch_next >= nch) begin
               ch_in    = '0;
               frame_in = frame_ff + DATA_W'(1);
               if (phase_ff + DATA_W'(1) == step_ff) begin
                  phase_in = '0;
                  if (gi_ff != GI_SAT) begin
                     gi_in = gi_ff + GI_W'(1);
                  end
               end else begin
                  phase_in = phase_ff + DATA_W'(1);
               end
            end else begin
               ch_in = CH_W'(ch_next);
            end
         end
      end

      case (rs_ff)
         RS_IDLE: begin
         end
         RS_STEP: begin
            step_in = (step_quo == '0) ? DATA_W'(1) : step_quo;
            rs_in   = RS_GAIN;
         end
         RS_GAIN: begin
            rs_in = RS_GAIN_WAIT;
         end
         RS_GAIN_WAIT: begin
            if (div_done) begin
               gi_in    = (div_quo > DATA_W'(GAIN_STEPS)) ? GI_SAT : GI_W'(div_quo);
               phase_in = div_rem;
               rs_in    = RS_IDLE;
            end
         end
         default: begin
            rs_in = RS_IDLE;
         end
      endcase

      // a new ramp length restarts the resync
      if (total_written) begin
         rs_in = RS_STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= '0;
         phase_ff <= '0;
         step_ff  <= DATA_W'(1);
         gi_ff    <= '0;
         ch_ff    <= '0;
         rs_ff    <= RS_IDLE;
      end else begin
         frame_ff <= frame_in;
         phase_ff <= phase_in;
         step_ff  <= step_in;
         gi_ff    <= gi_in;
         ch_ff    <= ch_in;
         rs_ff    <= rs_in;
      end
   end

endmodule

FILE: sv/pcmr_queue.sv
// Short FIFO that decouples the front end from the gain datapath.
// Depends on pcmr_pkg for the entry type and depth.
module pcmr_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  pcmr_pkg::q_entry_type push_entry,
   input  logic                  pop,
   output pcmr_pkg::q_entry_type head,
   output logic                  not_empty,
   output logic                  full
);
   import pcmr_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   q_entry_type      mem [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full      = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign head      = mem[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ff] <= push_entry;
      end
   end

endmodule

FILE: sv/pcmr_back.sv
// Gain datapath: decode, shift-add gain over two stages, re-encode, output register.
// Depends on pcmr_pkg.
module pcmr_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [pcmr_pkg::FMT_W-1:0]  sample_format,
   input  pcmr_pkg::q_entry_type       head,
   input  logic                        head_valid,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [pcmr_pkg::DATA_W-1:0] rsp_out_word,
   output logic                        rsp_ramp_done
);
   import pcmr_pkg::*;

   localparam int ACC_W = DATA_W + 2;

   function automatic logic [DATA_W-1:0] decode(input logic [DATA_W-1:0] w,
                                                input logic [FMT_W-1:0] f);
      logic [7:0] b0, b1, b2, b3;
      logic [7:0] u;
      b0 = w[7:0];
      b1 = w[15:8];
      b2 = w[23:16];
      b3 = w[31:24];
      u  = b0 ^ U8_BIAS;
      case (f)
         FMT_S8:    decode = {{24{b0[7]}}, b0};
         FMT_U8:    decode = {{24{u[7]}}, u};
         FMT_S16LE: decode = {{16{b1[7]}}, b1, b0};
         FMT_S16BE: decode = {{16{b0[7]}}, b0, b1};
         FMT_S24LE: decode = {{8{b2[7]}}, b2, b1, b0};
         FMT_S24BE: decode = {{8{b0[7]}}, b0, b1, b2};
         FMT_S32LE: decode = w;
         default:   decode = {b0, b1, b2, b3};
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] encode(input logic [DATA_W-1:0] v,
                                                input logic [DATA_W-1:0] w,
                                                input logic [FMT_W-1:0] f);
      case (f)
         FMT_S8:    encode = {w[31:8], v[7:0]};
         FMT_U8:    encode = {w[31:8], v[7:0] ^ U8_BIAS};
         FMT_S16LE: encode = {w[31:16], v[15:8], v[7:0]};
         FMT_S16BE: encode = {w[31:16], v[7:0], v[15:8]};
         FMT_S24LE: encode = {w[31:24], v[23:16], v[15:8], v[7:0]};
         FMT_S24BE: encode = {w[31:24], v[7:0], v[15:8], v[23:16]};
         FMT_S32LE: encode = v;
         default:   encode = {v[7:0], v[15:8], v[23:16], v[31:24]};
      endcase
   endfunction

   logic                    a_valid_ff, a_valid_in;
   logic [DATA_W-1:0]       a_word_ff;
   logic                    a_done_ff;
   logic signed [ACC_W-1:0] a_sum_ff [4];

   logic                    b_valid_ff, b_valid_in;
   logic [DATA_W-1:0]       b_word_ff;
   logic                    b_done_ff;
   logic signed [ACC_W-1:0] b_sum_ff [2];

   logic                    o_valid_ff, o_valid_in;
   logic [DATA_W-1:0]       o_word_ff, o_word_in;
   logic                    o_done_ff;

   logic                    o_ready, b_ready, a_ready;
   logic [DATA_W-1:0]       s_dec;
   logic signed [ACC_W-1:0] s_ext;
   logic signed [ACC_W-1:0] term [8];
   logic signed [ACC_W-1:0] a_sum_in [4];
   logic signed [ACC_W-1:0] total;

   assign o_ready = !o_valid_ff || !rsp_stall;
   assign b_ready = !b_valid_ff || o_ready;
   assign a_ready = !a_valid_ff || b_ready;
   assign pop     = head_valid && a_ready;

   // bit i of the gain adds the sample shifted right by 8-i, floored
   always_comb begin
      s_dec = decode(head.word, sample_format);
      s_ext = ACC_W'(signed'(s_dec));
      for (int i = 0; i < 8; i++) begin
         term[i] = '0;
         if (head.gain[i]) begin
            term[i] = s_ext >>> (8 - i);
         end
      end
      for (int k = 0; k < 4; k++) begin
         a_sum_in[k] = term[2*k] + term[2*k+1];
      end
   end

   assign total      = b_sum_ff[0] + b_sum_ff[1];
   assign o_word_in  = b_done_ff ? b_word_ff
                                 : encode(total[DATA_W-1:0], b_word_ff, sample_format);
   assign a_valid_in = a_ready ? head_valid : a_valid_ff;
   assign b_valid_in = b_ready ? a_valid_ff : b_valid_ff;
   assign o_valid_in = o_ready ? b_valid_ff : o_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         a_word_ff <= head.word;
         a_done_ff <= head.done;
         for (int k = 0; k < 4; k++) begin
            a_sum_ff[k] <= a_sum_in[k];
         end
      end
      if (b_ready && a_valid_ff) begin
         b_word_ff   <= a_word_ff;
         b_done_ff   <= a_done_ff;
         b_sum_ff[0] <= a_sum_ff[0] + a_sum_ff[1];
         b_sum_ff[1] <= a_sum_ff[2] + a_sum_ff[3];
      end
      if (o_ready && b_valid_ff) begin
         o_word_ff <= o_word_in;
         o_done_ff <= b_done_ff;
      end
   end

   assign rsp_valid     = o_valid_ff;
   assign rsp_out_word  = o_word_ff;
   assign rsp_ramp_done = o_done_ff;

endmodule

FILE: sv/pcm_linear_gain_ramp_core.sv
// Top level of the PCM linear gain ramp core: registers, front end, queue, datapath.
// Depends on pcmr_pkg, pcmr_front, pcmr_queue and pcmr_back.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   func, sample_word, ramp_down
//   rsp      out        rsp_valid/rsp_stall   out_word, ramp_done
//   csr      in         csr_we                csr_index, csr_wdata
//
// One word a cycle sustained while no stall or resync holds the input; a result is
// registered in the queue, then in the datapath's a, b and output stages. The front
// end tracks the gain step count incrementally, so no divide sits in the sample path. A
// write to total_frames starts a resync: a reciprocal multiply for the step, then a
// serial division of the frame index; req_stall stays high until the division is done.
// Reset is synchronous and clears counters, queue and pipeline valids.
// rsp_stall backs up into a two-entry queue, then into req_stall.
module pcm_linear_gain_ramp_core #(
   parameter int MAX_CHANNELS = pcmr_pkg::DEF_MAX_CHANNELS,
   parameter int GAIN_STEPS   = pcmr_pkg::DEF_GAIN_STEPS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [pcmr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pcmr_pkg::DATA_W-1:0]    csr_wdata,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_func,
   input  logic [pcmr_pkg::DATA_W-1:0]    req_sample_word,
   input  logic                           req_ramp_down,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [pcmr_pkg::DATA_W-1:0]    rsp_out_word,
   output logic                           rsp_ramp_done
);
   import pcmr_pkg::*;

   logic [DATA_W-1:0]   total_ff, total_in;
   logic [CH_REG_W-1:0] chcnt_ff, chcnt_in;
   logic [FMT_W-1:0]    fmt_ff, fmt_in;
   logic                total_written;

   logic                q_push, q_pop, q_full, q_not_empty, fr_busy;
   q_entry_type         q_in, q_head;

   // register file: write only, out-of-range indexes drop
   assign total_written = csr_we && (csr_index == REG_TOTAL);

   always_comb begin
      total_in = total_ff;
      chcnt_in = chcnt_ff;
      fmt_in   = fmt_ff;
      if (csr_we) begin
         case (csr_index)
            REG_TOTAL:    total_in = csr_wdata;
            REG_CHANNELS: chcnt_in = csr_wdata[CH_REG_W-1:0];
            REG_FORMAT:   fmt_in   = csr_wdata[FMT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= TOTAL_RESET;
         chcnt_ff <= CHANNELS_RESET;
         fmt_ff   <= FORMAT_RESET;
      end else begin
         total_ff <= total_in;
         chcnt_ff <= chcnt_in;
         fmt_ff   <= fmt_in;
      end
   end

   // front end: classify the word, pick its gain, advance the frame counters
   pcmr_front #(
      .MAX_CHANNELS (MAX_CHANNELS),
      .GAIN_STEPS   (GAIN_STEPS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_sample_word (req_sample_word),
      .req_ramp_down   (req_ramp_down),
      .total_frames    (total_ff),
      .channel_count   (chcnt_ff),
      .total_written   (total_written),
      .queue_full      (q_full),
      .push            (q_push),
      .entry           (q_in),
      .busy            (fr_busy)
   );

   // hold classified words until the datapath takes them
   pcmr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in),
      .pop        (q_pop),
      .head       (q_head),
      .not_empty  (q_not_empty),
      .full       (q_full)
   );

   // decode, scale, re-encode and drive the result word
   pcmr_back u_back (
      .clock         (clock),
      .reset         (reset),
      .sample_format (fmt_ff),
      .head          (q_head),
      .head_valid    (q_not_empty),
      .pop           (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_word  (rsp_out_word),
      .rsp_ramp_done (rsp_ramp_done)
   );

`ifndef SYNTHESIS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("word pushed into a full queue");

   a_no_push_in_resync: assert property (@(posedge clock) disable iff (reset)
      fr_busy |-> !q_push)
      else $error("word accepted during gain resync");

   a_resync_stalls: assert property (@(posedge clock) disable iff (reset)
      total_written |=> req_stall)
      else $error("ramp length write did not stall the input");

   a_pop_only_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_not_empty)
      else $error("datapath popped an empty queue");
`endif

endmodule
